// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the spring edge force RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clk outside reset.
`define SEF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SEF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/sef_pkg.sv -----
// Types, constants and step functions of the spring edge force block.
`timescale 1ns / 1ps
package sef_pkg;

  localparam int DISP_W      = 24;
  localparam int REST_W      = 31;
  localparam int DIR_W       = 16;
  localparam int STRAIN_W    = 32;
  localparam int DIR_FRAC_BITS = 14;
  localparam int GUARD_BITS  = 7;
  localparam int STRAIN_FRAC = 16;

  localparam int SQ_W      = 2 * DISP_W;              // sum of squares fits (3 * 2^46)
  localparam int RAD_W     = SQ_W + 2 * GUARD_BITS;   // radicand
  localparam int ROOT_W    = RAD_W / 2;
  localparam int DIR_SHIFT = DIR_FRAC_BITS + GUARD_BITS;
  localparam int DNUM_W    = DISP_W + DIR_SHIFT + 1;
  localparam int DQ_W      = DIR_W;
  localparam int DEN_W     = REST_W + GUARD_BITS;
  localparam int SNUM_W    = ROOT_W + STRAIN_FRAC + 1;
  localparam int SQB       = STRAIN_W;                // strain quotient bits
  localparam int SQRT_STAGES = ROOT_W;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [DIR_W-1:0] DIR_ONE = DIR_W'(1 << DIR_FRAC_BITS);
  localparam logic [DIR_W-1:0] DIR_COLLAPSED =
    DIR_W'(((333 << DIR_FRAC_BITS) + 500) / 1000);
  localparam logic [STRAIN_W-1:0] STRAIN_MAX = 32'h7FFF_FFFF;
  localparam logic [STRAIN_W-1:0] STRAIN_ONE = STRAIN_W'(1 << STRAIN_FRAC);

  typedef struct packed {
    logic signed [DISP_W-1:0] disp_x;
    logic signed [DISP_W-1:0] disp_y;
    logic signed [DISP_W-1:0] disp_z;
    logic [REST_W-1:0]        rest_length;
  } in_word_t;

  typedef struct packed {
    logic signed [DIR_W-1:0]    dir_x;
    logic signed [DIR_W-1:0]    dir_y;
    logic signed [DIR_W-1:0]    dir_z;
    logic signed [STRAIN_W-1:0] strain;
    logic                       collapsed;
    logic                       saturated;
  } out_word_t;

  // per-edge data that rides along with the arithmetic
  typedef struct packed {
    logic [DISP_W-1:0] mag_x;
    logic [DISP_W-1:0] mag_y;
    logic [DISP_W-1:0] mag_z;
    logic              neg_x;
    logic              neg_y;
    logic              neg_z;
    logic [REST_W-1:0] rest;
    logic              collapsed;
    logic              rest_zero;
  } side_t;

  typedef struct packed {
    logic [SQ_W-1:0] s;
    side_t           side;
  } back_word_t;

  typedef struct packed {
    logic [RAD_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    side_t             side;
  } sqrt_state_t;

  typedef struct packed {
    logic [SNUM_W-1:0] rem_s;
    logic [SQB-1:0]    q_s;
    logic [DNUM_W-1:0] rem_x;
    logic [DNUM_W-1:0] rem_y;
    logic [DNUM_W-1:0] rem_z;
    logic [DQ_W-1:0]   q_x;
    logic [DQ_W-1:0]   q_y;
    logic [DQ_W-1:0]   q_z;
    logic              clip_x;
    logic              clip_y;
    logic              clip_z;
    logic              ovf;
    logic [ROOT_W-1:0] root;
    logic [DEN_W-1:0]  den;
    side_t             side;
  } div_state_t;

  // one digit of the restoring square root
  function automatic sqrt_state_t sqrt_step(sqrt_state_t st, int unsigned bitpos);
    logic [RAD_W+1:0] trial;
    sqrt_state_t      nx;
    nx    = st;
    trial = ((RAD_W+2)'(st.root) << (bitpos + 1)) | ((RAD_W+2)'(1) << (2 * bitpos));
    if ({2'b00, st.rem} >= trial) begin
      nx.rem  = st.rem - RAD_W'(trial);
      nx.root = st.root | (ROOT_W'(1) << bitpos);
    end
    return nx;
  endfunction

endpackage

// ----- hw/rtl/sef_in_if.sv -----
// Input word channel of the spring edge force block.
`timescale 1ns / 1ps
interface sef_in_if;
  logic               valid;
  logic               ready;
  sef_pkg::in_word_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/sef_out_if.sv -----
// Result word channel of the spring edge force block.
`timescale 1ns / 1ps
interface sef_out_if;
  logic               valid;
  logic               ready;
  sef_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/sef_front.sv -----
// Front end: accepts edges, squares the components and classifies the edge.
`timescale 1ns / 1ps
module sef_front (
  input  logic                clk,
  input  logic                rst,
  sef_in_if.sink              inp,
  input  logic                full,
  output logic                push,
  output sef_pkg::back_word_t push_data
);

  logic                             en;
  logic                             v1;
  logic                             v2;
  logic [sef_pkg::SQ_W-1:0]         sq_x;
  logic [sef_pkg::SQ_W-1:0]         sq_y;
  logic [sef_pkg::SQ_W-1:0]         sq_z;
  sef_pkg::side_t                   side_c;
  sef_pkg::side_t                   side1;
  sef_pkg::back_word_t              word2;

  assign en        = !v2 || !full;
  assign inp.ready = en;
  assign push      = v2 && !full;
  assign push_data = word2;

  always_comb begin
    side_c.neg_x     = inp.data.disp_x[sef_pkg::DISP_W-1];
    side_c.neg_y     = inp.data.disp_y[sef_pkg::DISP_W-1];
    side_c.neg_z     = inp.data.disp_z[sef_pkg::DISP_W-1];
    side_c.mag_x     = side_c.neg_x ? (~inp.data.disp_x + 1'b1) : inp.data.disp_x;
    side_c.mag_y     = side_c.neg_y ? (~inp.data.disp_y + 1'b1) : inp.data.disp_y;
    side_c.mag_z     = side_c.neg_z ? (~inp.data.disp_z + 1'b1) : inp.data.disp_z;
    side_c.rest      = inp.data.rest_length;
    side_c.collapsed = (inp.data.disp_x == '0) && (inp.data.disp_y == '0) &&
                       (inp.data.disp_z == '0);
    side_c.rest_zero = (inp.data.rest_length == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= inp.valid;
      v2 <= v1;
    end
    if (en) begin
      sq_x       <= side_c.mag_x * side_c.mag_x;
      sq_y       <= side_c.mag_y * side_c.mag_y;
      sq_z       <= side_c.mag_z * side_c.mag_z;
      side1      <= side_c;
      word2.s    <= sq_x + sq_y + sq_z;
      word2.side <= side1;
    end
  end

endmodule

// ----- hw/rtl/sef_fifo.sv -----
// Short queue between the front end and the back end.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sef_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  sef_pkg::back_word_t push_data,
  input  logic                pop,
  output sef_pkg::back_word_t pop_data,
  output logic                full,
  output logic                empty
);

  sef_pkg::back_word_t             mem [sef_pkg::FIFO_DEPTH];
  logic [sef_pkg::FIFO_AW-1:0]     wr_ptr;
  logic [sef_pkg::FIFO_AW-1:0]     rd_ptr;
  logic [sef_pkg::FIFO_CW-1:0]     count;

  assign full     = (count == sef_pkg::FIFO_CW'(sef_pkg::FIFO_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == sef_pkg::FIFO_AW'(sef_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == sef_pkg::FIFO_AW'(sef_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `SEF_ASSERT_NOW(a_fifo_bound, 1'b1, count <= sef_pkg::FIFO_CW'(sef_pkg::FIFO_DEPTH), "fifo overfilled")
  `SEF_ASSERT_NEXT(a_fifo_fill, push && !pop, !empty, "pushed word lost")

endmodule

// ----- hw/rtl/sef_sqrt.sv -----
// Pipelined restoring square root, one root bit per stage.
`timescale 1ns / 1ps
module sef_sqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  sef_pkg::back_word_t          in_word,
  output logic                         out_valid,
  output logic [sef_pkg::ROOT_W-1:0]   out_root,
  output sef_pkg::side_t               out_side
);

  localparam int N = sef_pkg::SQRT_STAGES;

  sef_pkg::sqrt_state_t st  [N+1];
  sef_pkg::sqrt_state_t nx  [N];
  logic                 vld [N+1];

  always_comb begin
    for (int k = 0; k < N; k++) begin
      nx[k] = sef_pkg::sqrt_step(st[k], N - 1 - k);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= N; k++) begin
        vld[k] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= in_valid;
      for (int k = 0; k < N; k++) begin
        vld[k+1] <= vld[k];
      end
    end
    if (en) begin
      st[0].rem  <= sef_pkg::RAD_W'(in_word.s) << (2 * sef_pkg::GUARD_BITS);
      st[0].root <= '0;
      st[0].side <= in_word.side;
      for (int k = 0; k < N; k++) begin
        st[k+1] <= nx[k];
      end
    end
  end

  assign out_valid = vld[N];
  assign out_root  = st[N].root;
  assign out_side  = st[N].side;

endmodule

// ----- hw/rtl/sef_div.sv -----
// Pipelined direction and strain dividers with the output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sef_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [sef_pkg::ROOT_W-1:0]   in_root,
  input  sef_pkg::side_t               in_side,
  output logic                         en,
  sef_out_if.source                    res
);

  localparam int N = sef_pkg::SQB;

  sef_pkg::div_state_t st  [N+1];
  sef_pkg::div_state_t nx  [N];
  logic                vld [N+1];
  sef_pkg::div_state_t setup;
  sef_pkg::out_word_t  fin;
  sef_pkg::out_word_t  out_q;
  logic                out_valid;
  logic [sef_pkg::DNUM_W-1:0] nx_x;
  logic [sef_pkg::DNUM_W-1:0] nx_y;
  logic [sef_pkg::DNUM_W-1:0] nx_z;
  logic [sef_pkg::SNUM_W-1:0] ns;

  function automatic logic [sef_pkg::DNUM_W-1:0] dir_num(
    logic [sef_pkg::DISP_W-1:0] mag, logic [sef_pkg::ROOT_W-1:0] root);
    return (sef_pkg::DNUM_W'(mag) << sef_pkg::DIR_SHIFT) + sef_pkg::DNUM_W'(root >> 1);
  endfunction

  function automatic sef_pkg::div_state_t div_step(sef_pkg::div_state_t s, int unsigned j);
    sef_pkg::div_state_t n;
    logic [sef_pkg::SNUM_W-1:0] ds;
    logic [sef_pkg::DNUM_W-1:0] dd;
    n  = s;
    ds = sef_pkg::SNUM_W'(s.den);
    dd = sef_pkg::DNUM_W'(s.root);
    if ((s.rem_s >> j) >= ds) begin
      n.rem_s  = s.rem_s - (ds << j);
      n.q_s[j] = 1'b1;
    end
    if (j < sef_pkg::DQ_W) begin
      if ((s.rem_x >> j) >= dd) begin
        n.rem_x  = s.rem_x - (dd << j);
        n.q_x[j] = 1'b1;
      end
      if ((s.rem_y >> j) >= dd) begin
        n.rem_y  = s.rem_y - (dd << j);
        n.q_y[j] = 1'b1;
      end
      if ((s.rem_z >> j) >= dd) begin
        n.rem_z  = s.rem_z - (dd << j);
        n.q_z[j] = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic logic [sef_pkg::DIR_W-1:0] dir_final(
    logic [sef_pkg::DQ_W-1:0] q, logic clip, logic neg, logic coll);
    logic [sef_pkg::DIR_W-1:0] m;
    m = (clip || (q > sef_pkg::DIR_ONE)) ? sef_pkg::DIR_ONE : q;
    if (coll) begin
      m = sef_pkg::DIR_COLLAPSED;
    end else if (neg) begin
      m = ~m + 1'b1;
    end
    return m;
  endfunction

  assign en = !out_valid || res.ready;

  always_comb begin
    nx_x = dir_num(in_side.mag_x, in_root);
    nx_y = dir_num(in_side.mag_y, in_root);
    nx_z = dir_num(in_side.mag_z, in_root);
    setup.den    = sef_pkg::DEN_W'(in_side.rest) << sef_pkg::GUARD_BITS;
    ns           = (sef_pkg::SNUM_W'(in_root) << sef_pkg::STRAIN_FRAC) +
                   sef_pkg::SNUM_W'(setup.den >> 1);
    setup.rem_s  = ns;
    setup.q_s    = '0;
    setup.ovf    = (ns >> sef_pkg::SQB) >= sef_pkg::SNUM_W'(setup.den);
    setup.rem_x  = nx_x;
    setup.rem_y  = nx_y;
    setup.rem_z  = nx_z;
    setup.q_x    = '0;
    setup.q_y    = '0;
    setup.q_z    = '0;
    // quotient of 2^16 or more is far past unit length
    setup.clip_x = (nx_x >> sef_pkg::DQ_W) >= sef_pkg::DNUM_W'(in_root);
    setup.clip_y = (nx_y >> sef_pkg::DQ_W) >= sef_pkg::DNUM_W'(in_root);
    setup.clip_z = (nx_z >> sef_pkg::DQ_W) >= sef_pkg::DNUM_W'(in_root);
    setup.root   = in_root;
    setup.side   = in_side;
  end

  always_comb begin
    for (int k = 0; k < N; k++) begin
      nx[k] = div_step(st[k], N - 1 - k);
    end
  end

  always_comb begin
    fin.dir_x = dir_final(st[N].q_x, st[N].clip_x, st[N].side.neg_x, st[N].side.collapsed);
    fin.dir_y = dir_final(st[N].q_y, st[N].clip_y, st[N].side.neg_y, st[N].side.collapsed);
    fin.dir_z = dir_final(st[N].q_z, st[N].clip_z, st[N].side.neg_z, st[N].side.collapsed);
    fin.collapsed = st[N].side.collapsed;
    if (st[N].side.rest_zero || st[N].ovf ||
        (st[N].q_s > sef_pkg::STRAIN_MAX + sef_pkg::STRAIN_ONE)) begin
      fin.strain    = sef_pkg::STRAIN_MAX;
      fin.saturated = 1'b1;
    end else begin
      fin.strain    = st[N].q_s - sef_pkg::STRAIN_ONE;
      fin.saturated = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= N; k++) begin
        vld[k] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int k = 0; k < N; k++) begin
        vld[k+1] <= vld[k];
      end
      out_valid <= vld[N];
    end
    if (en) begin
      st[0] <= setup;
      for (int k = 0; k < N; k++) begin
        st[k+1] <= nx[k];
      end
      out_q <= fin;
    end
  end

  assign res.valid = out_valid;
  assign res.data  = out_q;

  `SEF_ASSERT_NOW(a_collapsed_strain, out_valid && out_q.collapsed && !out_q.saturated, out_q.strain == -32'sd65536, "collapsed edge strain not -1")
  `SEF_ASSERT_NOW(a_dir_range_x, out_valid, (out_q.dir_x <= 16'sd16384) && (out_q.dir_x >= -16'sd16384), "dir_x beyond unit")

endmodule

// ----- hw/rtl/spring_edge_force_unit.sv -----
// Spring edge kernel: length, unit direction and strain of one edge per word.
// Throughput: one word per cycle unless the output is stalled; the square root
// (31 stages) and the dividers (32 stages) are fully pipelined, and a 4-word
// queue decouples front and back.
// Reset: synchronous active-high rst clears all valid bits and queue pointers.
`timescale 1ns / 1ps
module spring_edge_force_unit (
  input  logic      clk,
  input  logic      rst,
  sef_in_if.sink    inp,
  sef_out_if.source res
);

  // front end -> queue
  logic                           push;
  sef_pkg::back_word_t            push_data;
  logic                           full;
  // queue -> back end
  logic                           empty;
  logic                           pop;
  sef_pkg::back_word_t            pop_data;
  // back end: whole pipe advances when the output register is free or taken
  logic                           en;
  logic                           root_valid;
  logic [sef_pkg::ROOT_W-1:0]     root;
  sef_pkg::side_t                 root_side;

  assign pop = en && !empty;

  sef_front u_front (
    .clk       (clk),
    .rst       (rst),
    .inp       (inp),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  sef_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (full),
    .empty     (empty)
  );

  // length with 7 guard bits: floor(sqrt(S * 2^14))
  sef_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (pop),
    .in_word   (pop_data),
    .out_valid (root_valid),
    .out_root  (root),
    .out_side  (root_side)
  );

  // direction = |d| / length, strain = length / rest - 1, both rounded
  sef_div u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (root_valid),
    .in_root  (root),
    .in_side  (root_side),
    .en       (en),
    .res      (res)
  );

endmodule
